FILE: rtl/tmps_pkg.sv
package tmps_pkg;
  localparam int MAX_ROWS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 16;
  localparam int ROW_CNT_W      = 6;
  localparam int COL_W          = 5;
  localparam int TOTAL_W        = 21;
  localparam int OUT_VAL_W      = 16;
endpackage

FILE: rtl/tmps_in_if.sv
interface tmps_in_if #(parameter int VALUE_BITS = tmps_pkg::VALUE_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

FILE: rtl/tmps_out_if.sv
interface tmps_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tmps_pkg::OUT_VAL_W-1:0]  path_value;
  logic        [tmps_pkg::COL_W-1:0]      path_column;
  logic signed [tmps_pkg::TOTAL_W-1:0]    total_sum;
  logic                                   last_of_run;
  modport source (output valid, output path_value, output path_column,
                  output total_sum, output last_of_run, input ready);
  modport sink   (input valid, input path_value, input path_column,
                  input total_sum, input last_of_run, output ready);
endinterface

FILE: rtl/tmps_cell.sv
// one column cell: holds the best sum from the row below at its column
module tmps_cell #(
  parameter int SUM_W = 22
) (
  input  logic                    clk,
  input  logic                    load_en,
  input  logic                    upd_en,
  input  logic signed [SUM_W-1:0] load_val,
  input  logic signed [SUM_W-1:0] elem_val,
  input  logic signed [SUM_W-1:0] right_sum,
  output logic signed [SUM_W-1:0] sum_o
);
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_nxt;

  // load value, or node sum = element + larger child
  always_comb begin
    sum_nxt = sum_r;
    if (load_en) begin
      sum_nxt = load_val;
    end else if (upd_en) begin
      sum_nxt = elem_val + ((sum_r > right_sum) ? sum_r : right_sum);
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum_o = sum_r;
endmodule

FILE: rtl/triangle_max_path_sum_core.sv
// sequence: after the last element beat, the bottom row is loaded into the cells and each row
//   above is folded in; then each result beat follows a memory read of its path element,
//   and a result beat waits while the sink holds ready low
// throughput: one element beat per cycle while loading and cfg_we is low; input stalls during
//   compute and emit, since ready is high only in the load state
// reset: row count 1, load count 0, loading; memories are not cleared
module triangle_max_path_sum_core #(
  parameter int MAX_ROWS   = tmps_pkg::MAX_ROWS_DEF,
  parameter int VALUE_BITS = tmps_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tmps_pkg::ROW_CNT_W-1:0] cfg_wdata,
  tmps_in_if.sink                        in_ch,
  tmps_out_if.source                     out_ch
);
  localparam int DEPTH = (MAX_ROWS * (MAX_ROWS + 1)) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SUM_W = VALUE_BITS + RW + 1;
  localparam int BW    = SUM_W * MAX_ROWS;

  typedef enum logic [2:0] {ST_LOAD, ST_BOT, ST_UP, ST_WALK, ST_EMIT} state_t;

  state_t              state_r;
  logic [tmps_pkg::ROW_CNT_W-1:0] rc_r;
  logic [AW:0]         cnt_r;
  logic [RW-1:0]       row_r;
  logic [CW:0]         col_r;
  logic [AW:0]         base_r;
  logic [CW-1:0]       pc_r;
  logic                rd_v_r;
  logic [CW-1:0]       rd_col_r;
  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_q_r;
  logic [AW-1:0]       rd_addr;
  logic                rd_en;
  logic [BW-1:0]       sum_path_r [MAX_ROWS];
  logic signed [SUM_W-1:0] sums [MAX_ROWS];
  logic signed [SUM_W-1:0] total_r;
  logic [RW-1:0]       rows;
  logic [AW:0]         nodes;
  logic                in_acc;
  logic                out_acc;

  // effective row count and node count
  always_comb begin
    if (rc_r == '0) begin
      rows = RW'(1);
    end else if (32'(rc_r) > MAX_ROWS) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = RW'(rc_r);
    end
    nodes = (AW+1)'((32'(rows) * (32'(rows) + 1)) / 2);
  end

  assign in_ch.ready = (state_r == ST_LOAD) && !cfg_we;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // element memory write on load, single read port for compute and walk
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[cnt_r[AW-1:0]] <= in_ch.element_value;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // read address: base of current row plus column
  always_comb begin
    rd_addr = AW'(base_r + (AW+1)'(col_r));
    rd_en   = ((state_r == ST_BOT) || (state_r == ST_UP)) && (32'(col_r) < 32'(row_r) + 1);
    if (state_r == ST_WALK) begin
      rd_addr = AW'(base_r + (AW+1)'(pc_r));
      rd_en   = 1'b1;
    end
  end

  // cell row
  genvar gi;
  generate
    for (gi = 0; gi < MAX_ROWS; gi++) begin : g_cell
      logic ld, up;
      logic signed [SUM_W-1:0] rs;
      assign ld = rd_v_r && (state_r == ST_BOT) && (32'(rd_col_r) == gi);
      assign up = rd_v_r && (state_r == ST_UP) && (32'(rd_col_r) == gi);
      if (gi + 1 < MAX_ROWS) begin : g_r
        assign rs = sums[gi+1];
      end else begin : g_e
        assign rs = sums[gi];
      end
      tmps_cell #(.SUM_W(SUM_W)) u_cell (
        .clk      (clk),
        .load_en  (ld),
        .upd_en   (up),
        .load_val (SUM_W'($signed(rd_q_r))),
        .elem_val (SUM_W'($signed(rd_q_r))),
        .right_sum(rs),
        .sum_o    (sums[gi])
      );
    end
  endgenerate

  // snapshot of the cell row per row for the walk
  logic [BW-1:0] packed_sums;
  always_comb begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      packed_sums[i*SUM_W +: SUM_W] = sums[i];
    end
  end

  // total saturation
  logic signed [tmps_pkg::TOTAL_W-1:0] total_sat;
  always_comb begin
    if (64'(total_r) > 64'((1 << (tmps_pkg::TOTAL_W-1)) - 1)) begin
      total_sat = {1'b0, {(tmps_pkg::TOTAL_W-1){1'b1}}};
    end else if (64'(total_r) < -64'(1 << (tmps_pkg::TOTAL_W-1))) begin
      total_sat = {1'b1, {(tmps_pkg::TOTAL_W-1){1'b0}}};
    end else begin
      total_sat = tmps_pkg::TOTAL_W'(total_r);
    end
  end

  logic out_v_r;
  assign out_ch.valid       = out_v_r;
  assign out_ch.path_value  = tmps_pkg::OUT_VAL_W'($signed(rd_q_r));
  assign out_ch.path_column = tmps_pkg::COL_W'(pc_r);
  assign out_ch.total_sum   = total_sat;
  assign out_ch.last_of_run = (32'(row_r) + 1 == 32'(rows));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      rc_r    <= tmps_pkg::ROW_CNT_W'(1);
      cnt_r   <= '0;
      rd_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      rd_v_r   <= rd_en && (state_r != ST_WALK);
      rd_col_r <= CW'(col_r);
      if (cfg_we) begin
        rc_r    <= cfg_wdata;
        cnt_r   <= '0;
        state_r <= ST_LOAD;
      end else begin
        case (state_r)
          ST_LOAD: begin
            if (in_acc) begin
              if (cnt_r + 1'b1 >= nodes) begin
                cnt_r   <= '0;
                row_r   <= RW'(rows - 1'b1);
                base_r  <= (AW+1)'((32'(rows) - 1) * 32'(rows) / 2);
                col_r   <= '0;
                state_r <= ST_BOT;
              end else begin
                cnt_r <= cnt_r + 1'b1;
              end
            end
          end
          ST_BOT, ST_UP: begin
            if (32'(col_r) < 32'(row_r) + 1) begin
              col_r <= col_r + 1'b1;
            end else if (!rd_v_r) begin
              sum_path_r[row_r[CW-1:0]] <= packed_sums;
              if (row_r == '0) begin
                total_r <= sums[0];
                pc_r    <= '0;
                base_r  <= '0;
                state_r <= ST_WALK;
              end else begin
                row_r   <= row_r - 1'b1;
                base_r  <= base_r - (AW+1)'(row_r);
                col_r   <= '0;
                state_r <= ST_UP;
              end
            end
          end
          ST_WALK: begin
            out_v_r <= 1'b1;
            state_r <= ST_EMIT;
          end
          ST_EMIT: begin
            if (out_acc) begin
              out_v_r <= 1'b0;
              if (32'(row_r) + 1 == 32'(rows)) begin
                state_r <= ST_LOAD;
              end else begin
                // step down: left only when strictly larger
                if (!($signed(sum_path_r[row_r[CW-1:0] + 1'b1][32'(pc_r)*SUM_W +: SUM_W]) >
                      $signed(sum_path_r[row_r[CW-1:0] + 1'b1][(32'(pc_r)+1)*SUM_W +: SUM_W]))) begin
                  pc_r <= pc_r + 1'b1;
                end
                base_r  <= base_r + (AW+1)'(row_r) + 1'b1;
                row_r   <= row_r + 1'b1;
                state_r <= ST_WALK;
              end
            end
          end
          default: state_r <= ST_LOAD;
        endcase
      end
    end
  end
endmodule

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS = tmps_pkg::MAX_ROWS_DEF;
  localparam int DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;
  localparam int LIMIT = 400000;
  localparam int RANDOM_BEATS = 240;

  typedef struct {
    logic signed [tmps_pkg::OUT_VAL_W-1:0] value;
    logic [tmps_pkg::COL_W-1:0]            column;
    logic signed [tmps_pkg::TOTAL_W-1:0]   total;
    logic                                  last;
  } path_step_t;

  typedef enum {OP_CFG, OP_BEAT, OP_WANT} op_t;

  typedef struct {
    op_t        op;
    logic [15:0] val;
    path_step_t want;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tmps_pkg::ROW_CNT_W-1:0] cfg_wdata;

  tmps_in_if  in_ch ();
  tmps_out_if out_ch ();

  triangle_max_path_sum_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // predictor state
  logic [tmps_pkg::ROW_CNT_W-1:0] row_cfg;
  int signed            tri_elem [DEPTH];
  int                   fill_cnt;
  path_step_t           path_q [$];
  path_step_t           fresh_q [$];
  script_row_t          script [$];

  int err_cnt;
  int cycle_cnt;
  int beat_cnt;
  int result_cnt;
  int triangle_cnt;
  bit quiet;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int rows_used();
    if (row_cfg == 0) return 1;
    if (row_cfg > MAX_ROWS) return MAX_ROWS;
    return int'(row_cfg);
  endfunction

  function automatic int node(int r, int c);
    return r * (r + 1) / 2 + c;
  endfunction

  // best path sum, bottom-up, then walk from the apex
  function automatic void solve_triangle(logic signed [15:0] v);
    int rows;
    int col;
    int signed best [DEPTH];
    int signed total;
    path_step_t s;
    rows = rows_used();
    fresh_q.delete();
    if (fill_cnt >= rows * (rows + 1) / 2) fill_cnt = 0;
    tri_elem[fill_cnt] = 32'(v);
    fill_cnt++;
    if (fill_cnt < rows * (rows + 1) / 2) return;
    for (int c = 0; c < rows; c++)
      best[node(rows - 1, c)] = tri_elem[node(rows - 1, c)];
    for (int r = rows - 2; r >= 0; r--)
      for (int c = 0; c <= r; c++)
        best[node(r, c)] = tri_elem[node(r, c)] +
          ((best[node(r + 1, c)] > best[node(r + 1, c + 1)]) ?
           best[node(r + 1, c)] : best[node(r + 1, c + 1)]);
    total = best[0];
    if (total > (1 << 20) - 1) total = (1 << 20) - 1;
    if (total < -(1 << 20)) total = -(1 << 20);
    col = 0;
    for (int k = 0; k < rows; k++) begin
      // left child only when strictly better
      if (k > 0 && !(best[node(k, col)] > best[node(k, col + 1)])) col++;
      s.value  = tmps_pkg::OUT_VAL_W'(tri_elem[node(k, col)]);
      s.column = tmps_pkg::COL_W'(col);
      s.total  = tmps_pkg::TOTAL_W'(total);
      s.last   = (k == rows - 1);
      fresh_q = {fresh_q, s};
    end
    fill_cnt = 0;
    triangle_cnt++;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h7fff;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    // narrow values make ties between children common
    if (r < 4) return 16'($signed($urandom_range(0, 6)) - 3);
    return 16'($urandom);
  endfunction

  task automatic write_rows(input logic [tmps_pkg::ROW_CNT_W-1:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    row_cfg = v;
    fill_cnt = 0;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one element beat; expected path steps are queued at acceptance when keep is set
  task automatic send_element(input logic [15:0] v, input bit keep);
    int g;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.element_value = v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beat_cnt++;
    solve_triangle(v);
    if (keep) path_q = {path_q, fresh_q};
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // drop valid, then wait until every expected result has come
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (path_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_row(input op_t op, input int v);
    script_row_t e;
    e.op = op;
    e.val = 16'(v);
    e.want = '{default: '0};
    script = {script, e};
  endtask

  task automatic add_want(input int v, input int c, input int t, input bit l);
    script_row_t e;
    e.op = OP_WANT;
    e.val = '0;
    e.want.value = tmps_pkg::OUT_VAL_W'(v);
    e.want.column = tmps_pkg::COL_W'(c);
    e.want.total = tmps_pkg::TOTAL_W'(t);
    e.want.last = l;
    script = {script, e};
  endtask

  // result side backpressure
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
        stall = gap_len();
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    path_step_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_cnt++;
      if (path_q.size() == 0) begin
        $error("unexpected result beat: value %0d column %0d",
               out_ch.path_value, out_ch.path_column);
        err_cnt++;
      end else begin
        e = path_q.pop_front();
        if (out_ch.path_value !== e.value) begin
          $error("path_value: expected %0d actual %0d", e.value, out_ch.path_value);
          err_cnt++;
        end
        if (out_ch.path_column !== e.column) begin
          $error("path_column: expected %0d actual %0d", e.column, out_ch.path_column);
          err_cnt++;
        end
        if (out_ch.total_sum !== e.total) begin
          $error("total_sum: expected %0d actual %0d", e.total, out_ch.total_sum);
          err_cnt++;
        end
        if (out_ch.last_of_run !== e.last) begin
          $error("last_of_run: expected %0d actual %0d", e.last, out_ch.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus
  initial begin
    int rows;
    int nodes;
    logic [tmps_pkg::ROW_CNT_W-1:0] cfg_v;
    bit keep;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.element_value = '0;
    row_cfg = 1;
    fill_cnt = 0;
    err_cnt = 0;
    cycle_cnt = 0;
    beat_cnt = 0;
    result_cnt = 0;
    triangle_cnt = 0;
    quiet = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, a zero row count, ties, abandoned load
    add_row(OP_BEAT, 16'h7fff);
    add_want(32767, 0, 32767, 1);
    add_row(OP_BEAT, 16'h8000);
    add_want(-32768, 0, -32768, 1);
    add_row(OP_CFG, 0);
    add_row(OP_BEAT, 5);
    add_want(5, 0, 5, 1);
    add_row(OP_CFG, 2);
    add_row(OP_BEAT, 1);
    add_row(OP_BEAT, 7);
    add_row(OP_BEAT, 7);
    add_want(1, 0, 8, 0);
    add_want(7, 1, 8, 1);
    add_row(OP_BEAT, 0);
    add_row(OP_BEAT, 9);
    add_row(OP_BEAT, 3);
    add_want(0, 0, 9, 0);
    add_want(9, 0, 9, 1);
    add_row(OP_CFG, 3);
    add_row(OP_BEAT, 100);
    add_row(OP_BEAT, 200);
    add_row(OP_CFG, 2);
    add_row(OP_BEAT, 16'hffff);
    add_row(OP_BEAT, 16'hfffe);
    add_row(OP_BEAT, 16'hfffd);
    add_want(-1, 0, -3, 0);
    add_want(-2, 0, -3, 1);
    add_row(OP_CFG, 3);
    for (int i = 1; i <= 6; i++) add_row(OP_BEAT, i);
    add_row(OP_CFG, 2);
    repeat (3) add_row(OP_BEAT, 16'h7fff);

    foreach (script[i]) begin
      case (script[i].op)
        OP_CFG: begin
          drain();
          write_rows(script[i].val[tmps_pkg::ROW_CNT_W-1:0]);
        end
        OP_BEAT: begin
          // typed expectations after a beat are queued before it goes out
          keep = 1'b1;
          for (int j = i + 1; j < script.size() && script[j].op == OP_WANT; j++) begin
            path_q = {path_q, script[j].want};
            keep = 1'b0;
          end
          send_element(script[i].val, keep);
        end
        default: begin
        end
      endcase
    end
    drain();

    // random phases: one mid-size triangle, then mostly small ones
    for (int ph = 0; beat_cnt < RANDOM_BEATS || ph < 3; ph++) begin
      if (ph == 0) cfg_v = 6'd12;
      else if ($urandom_range(0, 9) == 0)
        cfg_v = tmps_pkg::ROW_CNT_W'($urandom_range(7, 10));
      else cfg_v = tmps_pkg::ROW_CNT_W'($urandom_range(0, 6));
      quiet = ($urandom_range(0, 3) == 0);
      drain();
      write_rows(cfg_v);
      rows = rows_used();
      nodes = rows * (rows + 1) / 2;
      for (int t = 0; t < ((rows > 8) ? 1 : $urandom_range(1, 4)); t++) begin
        // sometimes hold off until the block has emptied
        if ($urandom_range(0, 3) == 0) drain();
        for (int n = 0; n < nodes; n++) send_element(pick_value(), 1'b1);
      end
      // occasionally abandon a partial load before the next setting
      if (nodes > 1 && $urandom_range(0, 4) == 0)
        for (int n = 0; n < $urandom_range(1, nodes - 1); n++)
          send_element(pick_value(), 1'b1);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    drain();
    repeat (40) @(posedge clk);
    if (path_q.size() != 0) begin
      $error("%0d path steps never arrived", path_q.size());
      err_cnt++;
    end
    $display("covered %0d element beats, %0d triangles, %0d path steps checked",
             beat_cnt, triangle_cnt, result_cnt);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
